// File: rtl/mm4_pkg.sv
package mm4_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int ROWS       = 4;
    localparam int COLS       = 4;
    localparam int ROW_AW     = $clog2(ROWS);
    localparam int ROW_W      = COLS * DATA_WIDTH;
    localparam int PROD_W     = 2 * DATA_WIDTH;
    localparam int SHIFT_W    = PROD_W - FRAC_BITS;
    localparam int ACC_W      = SHIFT_W + $clog2(COLS);

    // one stored matrix row, element j in slot j
    typedef logic [COLS-1:0][DATA_WIDTH-1:0] t_row;

    typedef struct packed {
        logic [ROW_AW-1:0]             row_index;
        logic signed [DATA_WIDTH-1:0] left_col0;
        logic signed [DATA_WIDTH-1:0] left_col1;
        logic signed [DATA_WIDTH-1:0] left_col2;
        logic signed [DATA_WIDTH-1:0] left_col3;
        logic signed [DATA_WIDTH-1:0] right_col0;
        logic signed [DATA_WIDTH-1:0] right_col1;
        logic signed [DATA_WIDTH-1:0] right_col2;
        logic signed [DATA_WIDTH-1:0] right_col3;
        logic                          compute_now;
    } t_in_item;

    typedef struct packed {
        logic [ROW_AW-1:0]             out_row;
        logic signed [DATA_WIDTH-1:0] prod_col0;
        logic signed [DATA_WIDTH-1:0] prod_col1;
        logic signed [DATA_WIDTH-1:0] prod_col2;
        logic signed [DATA_WIDTH-1:0] prod_col3;
        logic                          final_row;
    } t_out_item;

    // per-lane pipeline strobes
    typedef struct packed {
        logic mul_en;
        logic acc_en;
        logic acc_clr;
    } t_lane_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_DRAIN
    } t_state;

endpackage

// File: rtl/mm4_ram.sv
module mm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/mm4_lane.sv
module mm4_lane (
    input  logic                                  i_clk,
    input  mm4_pkg::t_lane_ctl                    i_ctl,
    input  logic signed [mm4_pkg::DATA_WIDTH-1:0] i_a,
    input  logic signed [mm4_pkg::DATA_WIDTH-1:0] i_b,
    output logic signed [mm4_pkg::DATA_WIDTH-1:0] o_sum
);
    import mm4_pkg::*;

    logic signed [PROD_W-1:0]  r_prod;
    logic signed [ACC_W-1:0]   r_acc;
    logic signed [SHIFT_W-1:0] shifted;
    logic signed [ACC_W-1:0]   acc_base;
    logic signed [ACC_W-1:0]   n_acc;
    logic signed [ACC_W-1:0]   sat_max;
    logic signed [ACC_W-1:0]   sat_min;

    // full-width signed product
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    // drop fraction bits (floor), then accumulate exactly
    assign shifted  = signed'(r_prod[PROD_W-1:FRAC_BITS]);
    assign acc_base = i_ctl.acc_clr ? '0 : r_acc;
    assign n_acc    = acc_base + ACC_W'(shifted);

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_en) begin
            r_acc <= n_acc;
        end
    end

    // clamp to the signed element range
    assign sat_max = ACC_W'(signed'({1'b0, {(DATA_WIDTH-1){1'b1}}}));
    assign sat_min = ACC_W'(signed'({1'b1, {(DATA_WIDTH-1){1'b0}}}));

    always_comb begin
        if (r_acc > sat_max) begin
            o_sum = sat_max[DATA_WIDTH-1:0];
        end else if (r_acc < sat_min) begin
            o_sum = sat_min[DATA_WIDTH-1:0];
        end else begin
            o_sum = r_acc[DATA_WIDTH-1:0];
        end
    end

endmodule

// File: rtl/matrix4_multiply.sv
// a row-load request is accepted only while idle; with compute_now set the
// four product rows are computed in order, each waiting in S_DRAIN until the
// output register is free, and no new request is taken until the last is loaded.
// each product row needs 4 reads of the right-matrix memory, one per cycle.
// reset: synchronous, active low; both matrices read as zero until written.
module matrix4_multiply (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  mm4_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output mm4_pkg::t_out_item o_out_data
);
    import mm4_pkg::*;

    t_state              r_state, n_state;
    logic [ROW_AW-1:0]   r_row, n_row;
    logic [ROW_AW-1:0]   r_k, n_k;
    logic [ROWS-1:0]     r_lvalid, r_rvalid;
    logic                r_s1_valid;
    logic [ROW_AW-1:0]   r_s1_k;
    logic                r_s2_valid, r_s2_first, r_s2_last;
    logic                r_done;
    logic                r_out_valid;
    t_out_item           r_out_data;

    logic                in_accept;
    logic                ram_re;
    logic                load_out;
    logic [ROW_W-1:0]    left_wdata, right_wdata;
    logic [ROW_W-1:0]    left_rdata, right_rdata;
    t_row                left_row, right_row;
    t_lane_ctl           lane_ctl;
    logic signed [DATA_WIDTH-1:0] lane_a;
    logic signed [DATA_WIDTH-1:0] lane_b   [COLS];
    logic signed [DATA_WIDTH-1:0] lane_sum [COLS];

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;

    // row storage, one memory word per matrix row
    assign left_wdata  = {i_in_data.left_col3, i_in_data.left_col2,
                          i_in_data.left_col1, i_in_data.left_col0};
    assign right_wdata = {i_in_data.right_col3, i_in_data.right_col2,
                          i_in_data.right_col1, i_in_data.right_col0};

    mm4_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_left_ram (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (i_in_data.row_index),
        .i_wdata (left_wdata),
        .i_re    (ram_re),
        .i_raddr (r_row),
        .o_rdata (left_rdata)
    );

    mm4_ram #(.WIDTH(ROW_W), .DEPTH(ROWS)) u_right_ram (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (i_in_data.row_index),
        .i_wdata (right_wdata),
        .i_re    (ram_re),
        .i_raddr (r_k),
        .o_rdata (right_rdata)
    );

    assign left_row  = left_rdata;
    assign right_row = right_rdata;

    // sequencer: issue four right-row reads per product row, then drain
    always_comb begin
        n_state  = r_state;
        n_row    = r_row;
        n_k      = r_k;
        ram_re   = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept && i_in_data.compute_now) begin
                    n_state = S_ISSUE;
                    n_row   = '0;
                    n_k     = '0;
                end
            end
            S_ISSUE: begin
                ram_re = 1'b1;
                n_k    = r_k + 1'b1;
                if (r_k == ROW_AW'(COLS - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (r_done && (!r_out_valid || i_out_ready)) begin
                    load_out = 1'b1;
                    n_k      = '0;
                    if (r_row == ROW_AW'(ROWS - 1)) begin
                        n_state = S_IDLE;
                        n_row   = '0;
                    end else begin
                        n_state = S_ISSUE;
                        n_row   = r_row + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_k     <= n_k;
        end
    end

    // rows never written read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvalid <= '0;
            r_rvalid <= '0;
        end else if (in_accept) begin
            r_lvalid[i_in_data.row_index] <= 1'b1;
            r_rvalid[i_in_data.row_index] <= 1'b1;
        end
    end

    // pipeline tags for multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_s1_valid <= ram_re;
            r_s2_valid <= r_s1_valid;
            if (r_s2_valid && r_s2_last) begin
                r_done <= 1'b1;
            end else if (load_out) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_k     <= r_k;
        r_s2_first <= (r_s1_k == '0);
        r_s2_last  <= (r_s1_k == ROW_AW'(COLS - 1));
    end

    // lane operands: left element k times right row k
    assign lane_a = r_lvalid[r_row] ? signed'(left_row[r_s1_k]) : '0;

    assign lane_ctl.mul_en  = r_s1_valid;
    assign lane_ctl.acc_en  = r_s2_valid;
    assign lane_ctl.acc_clr = r_s2_first;

    for (genvar j = 0; j < COLS; j++) begin : g_lane
        assign lane_b[j] = r_rvalid[r_s1_k] ? signed'(right_row[j]) : '0;

        mm4_lane u_lane (
            .i_clk (i_clk),
            .i_ctl (lane_ctl),
            .i_a   (lane_a),
            .i_b   (lane_b[j]),
            .o_sum (lane_sum[j])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data.out_row   <= r_row;
            r_out_data.prod_col0 <= lane_sum[0];
            r_out_data.prod_col1 <= lane_sum[1];
            r_out_data.prod_col2 <= lane_sum[2];
            r_out_data.prod_col3 <= lane_sum[3];
            r_out_data.final_row <= (r_row == ROW_AW'(ROWS - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// File: tb/tb_matrix4_multiply.sv
module tb_matrix4_multiply;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TOTAL_REQUESTS = 500;
    localparam int SETTLE_CYCLES  = 60;
    localparam int IDLE_PERCENT   = 26;

    localparam logic signed [DATA_WIDTH-1:0] Q_ONE = 32'sh0001_0000;
    localparam logic signed [DATA_WIDTH-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] Q_MIN = 32'sh8000_0000;
    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    // value ranges for random matrix content
    typedef enum int {
        FILL_FULL,
        FILL_SMALL,
        FILL_MEDIUM,
        FILL_EDGE
    } t_fill;

    // tracks both stored matrices and the product rows still owed
    class product_checker;
        logic signed [DATA_WIDTH-1:0] left_m [ROWS][COLS];
        logic signed [DATA_WIDTH-1:0] right_m [ROWS][COLS];
        t_out_item pending_rows [$];
        int error_count;

        function new();
            foreach (left_m[r, c]) begin
                left_m[r][c]  = '0;
                right_m[r][c] = '0;
            end
            error_count = 0;
        endfunction

        // q16.16 dot product: floor-shift each full product, sum, saturate
        function logic signed [DATA_WIDTH-1:0] product_element(int r, int c);
            logic signed [63:0] a;
            logic signed [63:0] b;
            logic signed [63:0] acc;
            acc = '0;
            for (int k = 0; k < COLS; k++) begin
                a = left_m[r][k];
                b = right_m[k][c];
                acc += (a * b) >>> FRAC_BITS;
            end
            if (acc > SUM_MAX) return Q_MAX;
            if (acc < SUM_MIN) return Q_MIN;
            return acc[DATA_WIDTH-1:0];
        endfunction

        function void take_request(t_in_item req);
            t_out_item row;
            int r;
            r = req.row_index;
            left_m[r][0]  = req.left_col0;
            left_m[r][1]  = req.left_col1;
            left_m[r][2]  = req.left_col2;
            left_m[r][3]  = req.left_col3;
            right_m[r][0] = req.right_col0;
            right_m[r][1] = req.right_col1;
            right_m[r][2] = req.right_col2;
            right_m[r][3] = req.right_col3;
            if (!req.compute_now) return;
            for (int i = 0; i < ROWS; i++) begin
                row.out_row   = ROW_AW'(i);
                row.prod_col0 = product_element(i, 0);
                row.prod_col1 = product_element(i, 1);
                row.prod_col2 = product_element(i, 2);
                row.prod_col3 = product_element(i, 3);
                row.final_row = (i == ROWS - 1);
                pending_rows.push_back(row);
            end
        endfunction

        task report_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            error_count++;
        endtask

        task check_row(t_out_item got);
            t_out_item want;
            logic signed [DATA_WIDTH-1:0] got_cols [COLS];
            logic signed [DATA_WIDTH-1:0] want_cols [COLS];
            if (pending_rows.size() == 0) begin
                report_mismatch($sformatf("unexpected product row %0d", got.out_row));
                return;
            end
            want = pending_rows.pop_front();
            got_cols  = '{got.prod_col0, got.prod_col1, got.prod_col2, got.prod_col3};
            want_cols = '{want.prod_col0, want.prod_col1, want.prod_col2, want.prod_col3};
            if (got.out_row !== want.out_row)
                report_mismatch($sformatf("out_row: got %0d, expected %0d",
                                          got.out_row, want.out_row));
            for (int c = 0; c < COLS; c++) begin
                if (got_cols[c] !== want_cols[c])
                    report_mismatch($sformatf("row %0d col %0d: got %0d, expected %0d",
                                              want.out_row, c, got_cols[c], want_cols[c]));
            end
            if (got.final_row !== want.final_row)
                report_mismatch($sformatf("row %0d final_row: got %b, expected %b",
                                          want.out_row, got.final_row, want.final_row));
        endtask
    endclass

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_data   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;

    logic steady         = 1'b0;
    int   quiet_cycles   = 0;
    int   requests_sent  = 0;
    product_checker products;

    matrix4_multiply i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    // 2 ns clock
    initial begin
        forever #1 clk = ~clk;
    end

    // random backpressure on the product side
    always @(negedge clk) begin
        out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    // handshake monitor, scoreboard updates and watchdog
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready)
                products.take_request(in_data);
            if (out_valid && out_ready)
                products.check_row(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_matrix4_multiply failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // drive one request, with random idle cycles ahead of it
    task automatic send_request(input t_in_item req);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge clk); while (in_ready !== 1'b1);
        requests_sent++;
    endtask

    // hold off new requests until every owed product row has come back
    task automatic wait_for_products();
        @(negedge clk);
        in_valid <= 1'b0;
        while (products.pending_rows.size() != 0) @(negedge clk);
    endtask

    function automatic t_in_item uniform_row(int row, logic signed [DATA_WIDTH-1:0] lv,
                                             logic signed [DATA_WIDTH-1:0] rv, logic go);
        t_in_item req;
        req.row_index   = ROW_AW'(row);
        req.left_col0   = lv;
        req.left_col1   = lv;
        req.left_col2   = lv;
        req.left_col3   = lv;
        req.right_col0  = rv;
        req.right_col1  = rv;
        req.right_col2  = rv;
        req.right_col3  = rv;
        req.compute_now = go;
        return req;
    endfunction

    function automatic logic signed [DATA_WIDTH-1:0] random_element(t_fill fill);
        case (fill)
            FILL_SMALL:  return int'($urandom_range(0, 524288)) - 262144;
            FILL_MEDIUM: return int'($urandom_range(0, 33554432)) - 16777216;
            FILL_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return Q_MAX;
                    1: return Q_MIN;
                    2: return '0;
                    3: return Q_ONE;
                    4: return -Q_ONE;
                    default: return -1;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_row(int row, t_fill fill, logic go);
        t_in_item req;
        req.row_index   = ROW_AW'(row);
        req.left_col0   = random_element(fill);
        req.left_col1   = random_element(fill);
        req.left_col2   = random_element(fill);
        req.left_col3   = random_element(fill);
        req.right_col0  = random_element(fill);
        req.right_col1  = random_element(fill);
        req.right_col2  = random_element(fill);
        req.right_col3  = random_element(fill);
        req.compute_now = go;
        return req;
    endfunction

    // load some rows in shuffled order, compute on the last one
    task automatic send_sequence(int rows_used, t_fill fill);
        int order [ROWS];
        int j;
        int tmp;
        order = '{0, 1, 2, 3};
        for (int i = ROWS - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int n = 0; n < rows_used; n++)
            send_request(random_row(order[n], fill, n == rows_used - 1));
    endtask

    initial begin
        int   pick;
        logic pressure_done;
        t_fill fill;
        products      = new();
        pressure_done = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // rows never written still read as zero
        send_request(uniform_row(0, Q_ONE, Q_ONE, 1'b1));
        // saturation high, saturation low, min times min
        for (int r = 0; r < ROWS; r++)
            send_request(uniform_row(r, Q_MAX, Q_MAX, r == ROWS - 1));
        for (int r = 0; r < ROWS; r++)
            send_request(uniform_row(r, Q_MAX, Q_MIN, r == ROWS - 1));
        for (int r = 0; r < ROWS; r++)
            send_request(uniform_row(r, Q_MIN, Q_MIN, r == ROWS - 1));
        // shift rounds toward minus infinity
        for (int r = 0; r < ROWS; r++)
            send_request(uniform_row(r, -1, 1, r == ROWS - 1));
        // overwrite single rows, others keep their content
        send_request(uniform_row(2, '0, '0, 1'b1));
        send_request(uniform_row(1, Q_ONE, -Q_ONE, 1'b0));
        send_request(uniform_row(3, Q_ONE, -Q_ONE, 1'b1));
        wait_for_products();

        // random sequences, stray loads and partial sequences
        while (requests_sent < TOTAL_REQUESTS) begin
            steady = (requests_sent >= 200 && requests_sent < 300);
            if (!pressure_done && requests_sent >= 120) begin
                wait_for_products();
                pressure_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            fill = t_fill'($urandom_range(0, 3));
            if (pick < 7)
                send_sequence(ROWS, fill);
            else if (pick < 9)
                send_request(random_row($urandom_range(0, 3), fill,
                                        $urandom_range(0, 3) == 0));
            else
                send_sequence($urandom_range(1, 3), fill);
        end
        steady = 1'b0;

        wait_for_products();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (products.error_count == 0)
            $display("tb_matrix4_multiply passed");
        else
            $display("tb_matrix4_multiply failed");
        $finish;
    end

endmodule
